// File: hw/rtl/tcc_pkg.sv
package tcc_pkg;

  // number of cordic micro-rotations, capped by the arctangent table
  localparam int unsigned CORDIC_STAGES = 16;
  localparam int unsigned ATAN_ENTRIES  = 24;
  localparam int unsigned NCELL   = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int unsigned STAGE_W = $clog2(ATAN_ENTRIES);

  // square root cells: one result bit per cell for a 32-bit radicand
  localparam int unsigned SQRT_CELLS = 16;
  localparam int unsigned SQRT_W     = $clog2(SQRT_CELLS);

  // datapath widths
  localparam int unsigned VW = 56;  // vectoring x/y
  localparam int unsigned RW = 34;  // rotation x/y/z
  localparam int unsigned TW = 18;  // q16 sine and cosine
  localparam int unsigned PW = 34;  // field times trig products
  localparam int unsigned HW = 36;  // horizontal field sums

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic signed [RW-1:0] INV_GAIN = 34'sd652032874;

  localparam logic [31:0] ATAN_STEP [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef struct packed {
    logic               mode;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic signed [15:0] pitch_in;
    logic signed [15:0] roll_in;
  } in_t;

  typedef struct packed {
    logic signed [15:0] pitch_out;
    logic signed [15:0] roll_out;
    logic signed [15:0] heading;
  } out_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic        [31:0]   z;
    logic                 zero;
  } vec_t;

  typedef struct packed {
    logic signed [RW-1:0] x;
    logic signed [RW-1:0] y;
    logic signed [RW-1:0] z;
    logic                 flip;
  } rot_t;

  typedef struct packed {
    logic [31:0] v;
    logic [31:0] r;
  } sqrt_t;

  // 32-bit binary angle to rounded 16-bit angle
  function automatic logic [15:0] angle_to_out(input logic [31:0] a);
    logic [31:0] s;
    s = a + 32'h0000_8000;
    return s[31:16];
  endfunction

  // 16-bit count scaled by 2^16 into the vectoring width
  function automatic logic signed [VW-1:0] scale16(input logic signed [15:0] a);
    return {{(VW - 32){a[15]}}, a, 16'h0000};
  endfunction

  // quarter-turn pre-rotation into the right half plane
  function automatic vec_t vec_pre(input logic signed [VW-1:0] x,
                                   input logic signed [VW-1:0] y);
    vec_t v;
    v.x    = x;
    v.y    = y;
    v.z    = '0;
    v.zero = (x == '0) && (y == '0);
    if (x[VW-1]) begin
      if (!y[VW-1]) begin
        v.x = y;
        v.y = -x;
        v.z = QUARTER_TURN;
      end else begin
        v.x = -y;
        v.y = x;
        v.z = 32'h0 - QUARTER_TURN;
      end
    end
    return v;
  endfunction

  // fold the angle into [-pi/2, pi/2) and load the inverse gain
  function automatic rot_t rot_pre(input logic [31:0] a);
    rot_t        r;
    logic [31:0] af;
    af     = a;
    r.flip = 1'b0;
    if (a[31:30] == 2'b01 || a[31:30] == 2'b10) begin
      af     = a + HALF_TURN;
      r.flip = 1'b1;
    end
    r.x = INV_GAIN;
    r.y = '0;
    r.z = RW'(signed'(af));
    return r;
  endfunction

  // q30 rotation output rounded to q16, sign restored
  function automatic logic signed [TW-1:0] trig_out(input logic signed [RW-1:0] v,
                                                    input logic flip);
    logic signed [RW-1:0] t;
    t = (v + RW'(8192)) >>> 14;
    if (flip) begin
      t = -t;
    end
    return TW'(t);
  endfunction

endpackage

// File: hw/rtl/tcc_sqrt_cell.sv
module tcc_sqrt_cell (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [tcc_pkg::SQRT_W-1:0] stage_i,
  input  tcc_pkg::sqrt_t            d_i,
  output tcc_pkg::sqrt_t            q_o
);
  import tcc_pkg::*;

  sqrt_t       q_q, q_d;
  logic [4:0]  sh;
  logic [31:0] bitv;
  logic [31:0] rb;

  // one result bit: trial subtract of the current square term
  always_comb begin
    sh   = 5'd30 - {stage_i, 1'b0};
    bitv = 32'd1 << sh;
    rb   = d_i.r + bitv;
    q_d  = d_i;
    if (d_i.v >= rb) begin
      q_d.v = d_i.v - rb;
      q_d.r = (d_i.r >> 1) + bitv;
    end else begin
      q_d.r = d_i.r >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

// File: hw/rtl/tcc_vec_cell.sv
module tcc_vec_cell (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [tcc_pkg::STAGE_W-1:0] stage_i,
  input  tcc_pkg::vec_t              d_i,
  output tcc_pkg::vec_t              q_o
);
  import tcc_pkg::*;

  vec_t                 q_q, q_d;
  logic signed [VW-1:0] xs, ys;

  // vectoring micro-rotation: drive y toward zero, accumulate angle
  always_comb begin
    xs  = d_i.x >>> stage_i;
    ys  = d_i.y >>> stage_i;
    q_d = d_i;
    if (!d_i.y[VW-1]) begin
      q_d.x = d_i.x + ys;
      q_d.y = d_i.y - xs;
      q_d.z = d_i.z + ATAN_STEP[stage_i];
    end else begin
      q_d.x = d_i.x - ys;
      q_d.y = d_i.y + xs;
      q_d.z = d_i.z - ATAN_STEP[stage_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

// File: hw/rtl/tcc_rot_cell.sv
module tcc_rot_cell (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [tcc_pkg::STAGE_W-1:0] stage_i,
  input  tcc_pkg::rot_t              d_i,
  output tcc_pkg::rot_t              q_o
);
  import tcc_pkg::*;

  rot_t                 q_q, q_d;
  logic signed [RW-1:0] xs, ys;
  logic signed [RW-1:0] step;

  // rotation micro-rotation: drive z toward zero
  always_comb begin
    xs   = d_i.x >>> stage_i;
    ys   = d_i.y >>> stage_i;
    step = signed'({{(RW - 32){1'b0}}, ATAN_STEP[stage_i]});
    q_d  = d_i;
    if (!d_i.z[RW-1]) begin
      q_d.x = d_i.x - ys;
      q_d.y = d_i.y + xs;
      q_d.z = d_i.z - step;
    end else begin
      q_d.x = d_i.x + ys;
      q_d.y = d_i.y - xs;
      q_d.z = d_i.z + step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

// File: hw/rtl/tilt_compensated_compass_unit.sv
// throughput: one transaction per cycle unless stalled; square root, tilt,
// sine/cosine and heading cordic chains are fully unrolled rows of cells
// the whole pipeline holds when the output register is full and not taken
// reset clears all stage valid bits; data registers are not reset
module tilt_compensated_compass_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tcc_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tcc_pkg::out_t  out_data_o
);
  import tcc_pkg::*;

  localparam int unsigned N      = NCELL;
  localparam int unsigned P_SQ   = 1;
  localparam int unsigned P_VEC  = P_SQ + SQRT_CELLS;
  localparam int unsigned P_TILT = P_VEC + N;
  localparam int unsigned P_ROT  = P_TILT + 1;
  localparam int unsigned P_TRIG = P_ROT + N;
  localparam int unsigned P_HEAD = P_TRIG + 4;
  localparam int unsigned P_OUT  = P_HEAD + N;
  localparam int unsigned L      = P_OUT + 1;

  typedef struct packed {
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
  } tilt_t;

  typedef struct packed {
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
  } ang_t;

  logic [L-1:0] vld_q;
  logic         adv;

  // stall control
  assign adv        = !vld_q[P_OUT] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[L-2:0], in_valid_i};
    end
  end

  // sum of squares stage and side payload lines
  logic [31:0] sumsq_q, sumsq_d;
  in_t         sa_q [SQRT_CELLS+1];
  in_t         sb_q [N];
  tilt_t       tilt_q, tilt_d;
  tilt_t       sc_q [N];

  always_comb begin
    logic signed [31:0] ay2, az2;
    ay2     = in_data_i.accel_y * in_data_i.accel_y;
    az2     = in_data_i.accel_z * in_data_i.accel_z;
    sumsq_d = unsigned'(ay2) + unsigned'(az2);
  end

  // square root row
  sqrt_t sq_in [SQRT_CELLS];
  sqrt_t sq_out[SQRT_CELLS];

  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
    if (k == 0) begin : g_first
      assign sq_in[k] = '{v: sumsq_q, r: 32'h0};
    end else begin : g_next
      assign sq_in[k] = sq_out[k-1];
    end
    tcc_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .stage_i(SQRT_W'(k)),
      .d_i    (sq_in[k]),
      .q_o    (sq_out[k])
    );
  end

  // roll and pitch vectoring rows
  vec_t vr_in [N], vr_out[N];
  vec_t vp_in [N], vp_out[N];
  in_t  sa_end;

  assign sa_end = sa_q[SQRT_CELLS];

  for (genvar k = 0; k < N; k++) begin : g_tilt
    if (k == 0) begin : g_first
      assign vr_in[k] = vec_pre(scale16(sa_end.accel_z), scale16(sa_end.accel_y));
      assign vp_in[k] = vec_pre({{(VW - 32){1'b0}}, sq_out[SQRT_CELLS-1].r[15:0], 16'h0000},
                                scale16(sa_end.accel_x));
    end else begin : g_next
      assign vr_in[k] = vr_out[k-1];
      assign vp_in[k] = vp_out[k-1];
    end
    tcc_vec_cell u_roll (
      .clk_i  (clk_i),
      .en_i   (adv),
      .stage_i(STAGE_W'(k)),
      .d_i    (vr_in[k]),
      .q_o    (vr_out[k])
    );
    tcc_vec_cell u_pitch (
      .clk_i  (clk_i),
      .en_i   (adv),
      .stage_i(STAGE_W'(k)),
      .d_i    (vp_in[k]),
      .q_o    (vp_out[k])
    );
  end

  // tilt select: derived angles or supplied ones
  always_comb begin
    logic [31:0] rz, pz;
    rz = vr_out[N-1].zero ? 32'h0 : vr_out[N-1].z;
    pz = vp_out[N-1].zero ? 32'h0 : (32'h0 - vp_out[N-1].z);
    tilt_d.mag_x = sb_q[N-1].mag_x;
    tilt_d.mag_y = sb_q[N-1].mag_y;
    tilt_d.mag_z = sb_q[N-1].mag_z;
    if (sb_q[N-1].mode) begin
      tilt_d.pitch = sb_q[N-1].pitch_in;
      tilt_d.roll  = sb_q[N-1].roll_in;
    end else begin
      tilt_d.pitch = signed'(angle_to_out(pz));
      tilt_d.roll  = signed'(angle_to_out(rz));
    end
  end

  // sine and cosine rows for pitch and roll
  rot_t rp_in [N], rp_out[N];
  rot_t rr_in [N], rr_out[N];

  for (genvar k = 0; k < N; k++) begin : g_trig
    if (k == 0) begin : g_first
      assign rp_in[k] = rot_pre({tilt_q.pitch, 16'h0000});
      assign rr_in[k] = rot_pre({tilt_q.roll, 16'h0000});
    end else begin : g_next
      assign rp_in[k] = rp_out[k-1];
      assign rr_in[k] = rr_out[k-1];
    end
    tcc_rot_cell u_pitch (
      .clk_i  (clk_i),
      .en_i   (adv),
      .stage_i(STAGE_W'(k)),
      .d_i    (rp_in[k]),
      .q_o    (rp_out[k])
    );
    tcc_rot_cell u_roll (
      .clk_i  (clk_i),
      .en_i   (adv),
      .stage_i(STAGE_W'(k)),
      .d_i    (rr_in[k]),
      .q_o    (rr_out[k])
    );
  end

  // trig rounding, cross products, field products, field sums
  logic signed [TW-1:0] cp_q, sp_q, cr_q, sr_q;
  tilt_t                st_q;
  logic signed [TW-1:0] cp1_q, cr1_q, sr1_q, srsp_q, crsp_q;
  tilt_t                s1_q;
  logic signed [TW-1:0] srsp_d, crsp_d;
  logic signed [PW-1:0] p1_q, p2_q, p3_q, p4_q, p5_q;
  ang_t                 s2_q;
  logic signed [HW-1:0] hx_q, hy_q;
  ang_t                 s3_q;
  ang_t                 sd_q [N];

  always_comb begin
    logic signed [2*TW-1:0] a, b;
    a      = sr_q * sp_q;
    b      = cr_q * sp_q;
    srsp_d = TW'((a + (2*TW)'(32768)) >>> 16);
    crsp_d = TW'((b + (2*TW)'(32768)) >>> 16);
  end

  // heading vectoring row
  vec_t hv_in [N], hv_out[N];
  logic signed [VW-1:0] hx_w, hy_w;

  assign hx_w = VW'(hx_q) <<< 16;
  assign hy_w = -(VW'(hy_q) <<< 16);

  for (genvar k = 0; k < N; k++) begin : g_head
    if (k == 0) begin : g_first
      assign hv_in[k] = vec_pre(hx_w, hy_w);
    end else begin : g_next
      assign hv_in[k] = hv_out[k-1];
    end
    tcc_vec_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .stage_i(STAGE_W'(k)),
      .d_i    (hv_in[k]),
      .q_o    (hv_out[k])
    );
  end

  // output register
  out_t out_q, out_d;

  always_comb begin
    out_d.pitch_out = sd_q[N-1].pitch;
    out_d.roll_out  = sd_q[N-1].roll;
    out_d.heading   = signed'(angle_to_out(hv_out[N-1].zero ? 32'h0 : hv_out[N-1].z));
  end

  // data registers, all advancing together
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sumsq_q <= sumsq_d;
      sa_q[0] <= in_data_i;
      for (int k = 1; k <= SQRT_CELLS; k++) begin
        sa_q[k] <= sa_q[k-1];
      end
      sb_q[0] <= sa_end;
      for (int k = 1; k < N; k++) begin
        sb_q[k] <= sb_q[k-1];
      end
      tilt_q  <= tilt_d;
      sc_q[0] <= tilt_q;
      for (int k = 1; k < N; k++) begin
        sc_q[k] <= sc_q[k-1];
      end
      cp_q   <= trig_out(rp_out[N-1].x, rp_out[N-1].flip);
      sp_q   <= trig_out(rp_out[N-1].y, rp_out[N-1].flip);
      cr_q   <= trig_out(rr_out[N-1].x, rr_out[N-1].flip);
      sr_q   <= trig_out(rr_out[N-1].y, rr_out[N-1].flip);
      st_q   <= sc_q[N-1];
      cp1_q  <= cp_q;
      cr1_q  <= cr_q;
      sr1_q  <= sr_q;
      srsp_q <= srsp_d;
      crsp_q <= crsp_d;
      s1_q   <= st_q;
      p1_q   <= s1_q.mag_x * cp1_q;
      p2_q   <= s1_q.mag_y * srsp_q;
      p3_q   <= s1_q.mag_z * crsp_q;
      p4_q   <= s1_q.mag_y * cr1_q;
      p5_q   <= s1_q.mag_z * sr1_q;
      s2_q   <= '{pitch: s1_q.pitch, roll: s1_q.roll};
      hx_q   <= HW'(p1_q) + HW'(p2_q) + HW'(p3_q);
      hy_q   <= HW'(p4_q) - HW'(p5_q);
      s3_q   <= s2_q;
      sd_q[0] <= s3_q;
      for (int k = 1; k < N; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[P_OUT];
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted transaction did not enter the pipeline");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while output stalled");

  a_last_cell_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[P_OUT-1] && adv) |=> out_valid_o)
    else $error("heading result lost before output register");

  a_first_stage_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && adv) |=> vld_q[P_SQ])
    else $error("sum of squares stage lost a transaction");
`endif

endmodule

// File: dv/tilt_compensated_compass_unit_test.sv
module tilt_compensated_compass_unit_test;
  import tcc_pkg::*;

  localparam int unsigned ATAN_N      = 24;
  localparam int unsigned RANDOM_TXNS = 2000;
  localparam int unsigned PIPE_LAT    = 22 + 3 * CORDIC_STAGES;
  localparam int unsigned DRAIN_MAX   = 20000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic        MODE_ACCEL  = 1'b0;
  localparam logic        MODE_GIVEN  = 1'b1;

  localparam logic [31:0] ARC_STEP [ATAN_N] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  // stimulus row: sample plus optional hand-worked result
  typedef struct {
    in_t  smp;
    bit   known;
    out_t want;
  } row_t;

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_ready_o;
  in_t   in_data_i;
  logic  out_valid_o;
  logic  out_ready_i;
  out_t  out_data_o;

  out_t        heading_q[$];
  int unsigned n_sent;
  int unsigned n_recv;
  int unsigned n_bad;
  bit          quiet_phase;
  bit          hold_sink;

  tilt_compensated_compass_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // vectoring arctangent, 2^31 = pi
  function automatic logic [31:0] arc_tan2(input longint y, input longint x);
    logic [31:0] z;
    longint      t;
    longint      xs;
    longint      ys;
    z = '0;
    if (x == 0 && y == 0) return '0;
    x = x * 65536;
    y = y * 65536;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = 32'h4000_0000;
      end else begin
        x = -y;
        y = t;
        z = 32'hC000_0000;
      end
    end
    for (int i = 0; i < CORDIC_STAGES && i < ATAN_N; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARC_STEP[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARC_STEP[i];
      end
    end
    return z;
  endfunction

  // floor square root
  function automatic longint int_sqrt(input longint v);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // rotation cordic, q16 cosine and sine
  function automatic void sin_cos(input logic [31:0] a, output longint c, output longint s);
    bit     flip;
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    flip = 0;
    x = 652032874;
    y = 0;
    if (a[31:30] == 2'b01 || a[31:30] == 2'b10) begin
      a = a + 32'h8000_0000;
      flip = 1;
    end
    z = longint'(signed'(a));
    for (int i = 0; i < CORDIC_STAGES && i < ATAN_N; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ARC_STEP[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ARC_STEP[i]);
      end
    end
    x = (x + 8192) >>> 14;
    y = (y + 8192) >>> 14;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [15:0] to_bam16(input logic [31:0] a);
    logic [31:0] t;
    t = a + 32'h8000;
    return t[31:16];
  endfunction

  function automatic out_t predict_heading(input in_t d);
    longint      ax;
    longint      ay;
    longint      az;
    longint      mx;
    longint      my;
    longint      mz;
    longint      cp;
    longint      sp;
    longint      cr;
    longint      sr;
    longint      srsp;
    longint      crsp;
    longint      hx;
    longint      hy;
    logic [31:0] pitch;
    logic [31:0] roll;
    out_t        o;
    ax = d.accel_x;
    ay = d.accel_y;
    az = d.accel_z;
    mx = d.mag_x;
    my = d.mag_y;
    mz = d.mag_z;
    if (d.mode == MODE_ACCEL) begin
      roll  = arc_tan2(ay, az);
      pitch = 32'h0 - arc_tan2(ax, int_sqrt(ay * ay + az * az));
      roll  = {to_bam16(roll), 16'h0};
      pitch = {to_bam16(pitch), 16'h0};
    end else begin
      pitch = {d.pitch_in, 16'h0};
      roll  = {d.roll_in, 16'h0};
    end
    sin_cos(pitch, cp, sp);
    sin_cos(roll, cr, sr);
    srsp = (sr * sp + 32768) >>> 16;
    crsp = (cr * sp + 32768) >>> 16;
    hx = mx * cp + my * srsp + mz * crsp;
    hy = my * cr - mz * sr;
    o.pitch_out = to_bam16(pitch);
    o.roll_out  = to_bam16(roll);
    o.heading   = to_bam16(arc_tan2(-hy, hx));
    return o;
  endfunction

  function automatic in_t make_sample(input logic m, input int ax, input int ay,
                                      input int az, input int mx, input int my,
                                      input int mz, input int p, input int r);
    in_t d;
    d.mode = m;
    d.accel_x = 16'(ax);
    d.accel_y = 16'(ay);
    d.accel_z = 16'(az);
    d.mag_x = 16'(mx);
    d.mag_y = 16'(my);
    d.mag_z = 16'(mz);
    d.pitch_in = 16'(p);
    d.roll_in = 16'(r);
    return d;
  endfunction

  function automatic in_t rand_sample();
    in_t          d;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    d = raw[$bits(in_t)-1:0];
    // mostly realistic gravity magnitude, sometimes full-scale
    if ($urandom_range(0, 3) != 0) begin
      d.accel_x = 16'($signed($urandom_range(0, 8000)) - 4000);
      d.accel_y = 16'($signed($urandom_range(0, 8000)) - 4000);
      d.accel_z = 16'($signed($urandom_range(0, 8000)) - 4000);
    end
    return d;
  endfunction

  // send one transaction, with random idle bursts before it
  task automatic send_sample(input in_t d);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    heading_q.push_back(predict_heading(d));
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_sent++;
    @(negedge clk_i);
  endtask

  // sender
  initial begin
    row_t      rows[$];
    row_t      rw;
    int unsigned wait_cnt;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    quiet_phase = 1'b0;
    hold_sink   = 1'b0;
    n_sent = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table; hand-worked rows only where obvious
    rw.known = 1; rw.want = '0;
    rw.smp = make_sample(MODE_ACCEL, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(rw);
    rw.smp = make_sample(MODE_GIVEN, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(rw);
    rw.known = 0;
    rw.smp = make_sample(MODE_ACCEL, 0, 0, 16384, 1000, 0, 0, 0, 0); rows.push_back(rw);
    rw.smp = make_sample(MODE_ACCEL, 0, 0, 16384, 0, 1000, 0, 0, 0); rows.push_back(rw);
    rw.smp = make_sample(MODE_ACCEL, 0, 0, -16384, -1000, 0, 0, 0, 0); rows.push_back(rw);
    rw.smp = make_sample(MODE_ACCEL, -32768, 0, 0, 100, 100, 100, 0, 0); rows.push_back(rw);
    rw.smp = make_sample(MODE_ACCEL, 32767, 0, 0, 100, -100, 100, 0, 0); rows.push_back(rw);
    rw.smp = make_sample(MODE_ACCEL, -32768, -32768, -32768,
                         -32768, -32768, -32768, 0, 0); rows.push_back(rw);
    rw.smp = make_sample(MODE_ACCEL, 32767, 32767, 32767,
                         32767, 32767, 32767, 0, 0); rows.push_back(rw);
    rw.smp = make_sample(MODE_ACCEL, 0, -32768, 0, 500, 0, 0, 0, 0); rows.push_back(rw);
    rw.smp = make_sample(MODE_ACCEL, 0, 0, 0, 0, 0, 0, -1, -1); rows.push_back(rw);
    rw.smp = make_sample(MODE_GIVEN, 0, 0, 0, 1000, 0, 0, -32768, -32768); rows.push_back(rw);
    rw.smp = make_sample(MODE_GIVEN, 0, 0, 0, 1000, 0, 0, 32767, 32767); rows.push_back(rw);
    rw.smp = make_sample(MODE_GIVEN, -1, -1, -1, 0, 1000, 500, 16384, -16384); rows.push_back(rw);
    rw.smp = make_sample(MODE_GIVEN, 0, 0, 0, -32768, 32767, -32768, 8192, 8192);
    rows.push_back(rw);
    rw.smp = make_sample(MODE_GIVEN, 0, 0, 0, 1000, -1000, 0, -16384, 0); rows.push_back(rw);

    foreach (rows[k]) begin
      send_sample(rows[k].smp);
      if (rows[k].known) heading_q[$] = rows[k].want;
    end

    // random, with a long sink hold-off while still offering
    for (int unsigned k = 0; k < RANDOM_TXNS; k++) begin
      if (k == 300) hold_sink = 1'b1;
      if (k == RANDOM_TXNS * 3 / 4) quiet_phase = 1'b1;
      send_sample(rand_sample());
    end
    in_valid_i <= 1'b0;

    wait_cnt = 0;
    while (heading_q.size() != 0 && wait_cnt < DRAIN_MAX) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (PIPE_LAT) @(posedge clk_i);
    $display("covered %0d samples in both tilt modes incl. axis extremes and zero field",
             n_sent);
    $display("received %0d headings, %0d mismatches", n_recv, n_bad);
    if (n_bad == 0 && heading_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        out_ready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_sink = 1'b0;
        out_ready_i <= 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // checker
  initial begin
    out_t want;
    n_recv = 0;
    n_bad  = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        n_recv++;
        if (heading_q.size() == 0) begin
          n_bad++;
          if (n_bad <= MAX_REPORTS) $display("unexpected transaction %p", out_data_o);
        end else begin
          want = heading_q.pop_front();
          if (out_data_o.pitch_out !== want.pitch_out || out_data_o.roll_out !== want.roll_out
              || out_data_o.heading !== want.heading) begin
            n_bad++;
            if (n_bad <= MAX_REPORTS)
              $display("mismatch #%0d: expected p=%0d r=%0d h=%0d got p=%0d r=%0d h=%0d",
                       n_recv, want.pitch_out, want.roll_out, want.heading,
                       out_data_o.pitch_out, out_data_o.roll_out, out_data_o.heading);
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/tcc_pkg.sv
hw/rtl/tcc_sqrt_cell.sv
hw/rtl/tcc_vec_cell.sv
hw/rtl/tcc_rot_cell.sv
hw/rtl/tilt_compensated_compass_unit.sv
dv/tilt_compensated_compass_unit_test.sv
